// ===== sv/jls_pkg.sv =====
`default_nettype none
package jls_pkg;

  localparam int MAX_SIZE_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int OP_W     = 2;
  localparam int POS_W    = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 8;
  localparam int SIZE_W   = 7;
  localparam int FACTOR_W = 8;
  localparam int SHIFT_W  = 6;
  localparam int SWEEP_W  = 14;

  localparam logic [OP_W-1:0] OP_MATRIX = 2'd0;
  localparam logic [OP_W-1:0] OP_RHS    = 2'd1;
  localparam logic [OP_W-1:0] OP_GUESS  = 2'd2;
  localparam logic [OP_W-1:0] OP_START  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 2'd2;

  localparam logic [SIZE_W-1:0]   SIZE_RST   = 7'd64;
  localparam logic [FACTOR_W-1:0] FACTOR_RST = 8'd6;
  localparam logic [SHIFT_W-1:0]  SHIFT_RST  = 6'd46;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic zp_clr;
    logic zp_issue;
    logic mac_issue;
    logic mac_first;
    logic div_load;
    logic div_step;
    logic wr;
    logic sq_d;
    logic sq_o;
    logic sq_a;
    logic sums_clr;
    logic chk;
    logic out_ld;
    logic last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zp;
    logic conv;
    logic div_done;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/jls_ram.sv =====
`default_nettype none
module jls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/jls_datapath.sv =====
`default_nettype none
module jls_datapath #(
  parameter int MAX_SIZE    = jls_pkg::MAX_SIZE_DEF,
  parameter int VALUE_WIDTH = jls_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire jls_pkg::cmd_t                 cmd_i,
  output jls_pkg::status_t                   status_o,
  input  wire logic [$clog2(MAX_SIZE)-1:0]   row_i,
  input  wire logic [$clog2(MAX_SIZE)-1:0]   col_i,
  input  wire logic [jls_pkg::SHIFT_W-1:0]   tshift_i,
  input  wire logic [jls_pkg::SWEEP_W-1:0]   sweeps_i,
  input  wire logic [jls_pkg::OP_W-1:0]      operation_i,
  input  wire logic [jls_pkg::POS_W-1:0]     in_row_i,
  input  wire logic [jls_pkg::POS_W-1:0]     in_col_i,
  input  wire logic [VALUE_WIDTH-1:0]        value_i,
  output logic      [jls_pkg::POS_W-1:0]     index_o,
  output logic      [VALUE_WIDTH-1:0]        solution_o,
  output logic                               last_o,
  output logic                               converged_o,
  output logic                               zero_pivot_o,
  output logic      [jls_pkg::SWEEP_W-1:0]   sweeps_done_o
);
  import jls_pkg::*;

  localparam int VW     = VALUE_WIDTH;
  localparam int FRAC   = VW / 2;
  localparam int IDX_W  = $clog2(MAX_SIZE);
  localparam int MAT_D  = MAX_SIZE * MAX_SIZE;
  localparam int MAT_AW = $clog2(MAT_D);
  localparam int MW     = 2 * (VW + 1);
  localparam int ACC_W  = 2 * VW + IDX_W + 2;
  localparam int ES_W   = MW + IDX_W + 1;
  localparam int DCNT_W = $clog2(ACC_W + 1);

  // Load decoding.
  logic load_ok, mat_ok;
  logic [IDX_W-1:0] ld_row, ld_col;
  assign load_ok = int'(in_row_i) < MAX_SIZE;
  assign mat_ok  = load_ok && (int'(in_col_i) < MAX_SIZE);
  assign ld_row  = IDX_W'(in_row_i);
  assign ld_col  = IDX_W'(in_col_i);

  logic sel_q;
  logic [VW-1:0] xnew;

  // Matrix store.
  logic mat_we;
  logic [MAT_AW-1:0] mat_waddr, mat_raddr;
  logic [VW-1:0] mat_rd;
  assign mat_we    = cmd_i.load && (operation_i == OP_MATRIX) && mat_ok;
  assign mat_waddr = MAT_AW'(int'(ld_row) * MAX_SIZE + int'(ld_col));
  assign mat_raddr = MAT_AW'(int'(row_i) * MAX_SIZE + int'(col_i));

  jls_ram #(.WIDTH(VW), .DEPTH(MAT_D)) u_mat (
    .clk_i, .we_i(mat_we), .waddr_i(mat_waddr), .wdata_i(value_i),
    .raddr_i(mat_raddr), .rdata_o(mat_rd)
  );

  // Right-hand side.
  logic rhs_we;
  logic [VW-1:0] rhs_rd;
  assign rhs_we = cmd_i.load && (operation_i == OP_RHS) && load_ok;

  jls_ram #(.WIDTH(VW), .DEPTH(MAX_SIZE)) u_rhs (
    .clk_i, .we_i(rhs_we), .waddr_i(ld_row), .wdata_i(value_i),
    .raddr_i(row_i), .rdata_o(rhs_rd)
  );

  // Two solution banks: sel_q names the current one, a sweep writes the other.
  logic guess_we;
  logic b0_we, b1_we;
  logic [IDX_W-1:0] b_waddr;
  logic [VW-1:0] b_wdata, b0_rd, b1_rd, old_rd;
  assign guess_we = cmd_i.load && (operation_i == OP_GUESS) && load_ok;
  assign b0_we    = (guess_we && !sel_q) || (cmd_i.wr && sel_q);
  assign b1_we    = (guess_we && sel_q) || (cmd_i.wr && !sel_q);
  assign b_waddr  = cmd_i.load ? ld_row : row_i;
  assign b_wdata  = cmd_i.load ? value_i : xnew;
  assign old_rd   = sel_q ? b1_rd : b0_rd;

  jls_ram #(.WIDTH(VW), .DEPTH(MAX_SIZE)) u_bank0 (
    .clk_i, .we_i(b0_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .raddr_i(col_i), .rdata_o(b0_rd)
  );

  jls_ram #(.WIDTH(VW), .DEPTH(MAX_SIZE)) u_bank1 (
    .clk_i, .we_i(b1_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .raddr_i(col_i), .rdata_o(b1_rd)
  );

  // Pipeline tags for the read and multiply stages.
  logic v1_q, first1_q, diag1_q, zpchk1_q;
  logic v2_q, first2_q, diag2_q;
  logic zp_q, conv_q;

  // Shared multiplier.
  logic signed [VW:0]   ma, mb;
  logic signed [MW-1:0] prod_d;
  logic signed [MW-1:0] prod_q;
  logic signed [VW:0]   diff_q;
  logic [VW-1:0] diag_q, oldi_q, rhs_q;

  always_comb begin
    if (cmd_i.sq_d) begin
      ma = diff_q;
      mb = diff_q;
    end else if (cmd_i.sq_o) begin
      ma = $signed({oldi_q[VW-1], oldi_q});
      mb = $signed({oldi_q[VW-1], oldi_q});
    end else begin
      ma = $signed({mat_rd[VW-1], mat_rd});
      mb = $signed({old_rd[VW-1], old_rd});
    end
    prod_d = ma * mb;
  end

  // Row accumulator.
  logic [ACC_W-1:0] acc_q, rhs_ext, term;
  assign rhs_ext = {{(ACC_W-VW){rhs_q[VW-1]}}, rhs_q} << FRAC;
  assign term    = diag2_q ? '0 : {{(ACC_W-MW){prod_q[MW-1]}}, prod_q};

  // Restoring divider over the magnitude of the row sum.
  logic [ACC_W-1:0]  dvd_q, acc_mag;
  logic [VW-1:0]     rem_q, dm_q, diag_mag;
  logic [DCNT_W-1:0] dcnt_q;
  logic              neg_q;
  logic [VW:0]       trial;
  logic              qbit;
  assign acc_mag  = acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
  assign diag_mag = diag_q[VW-1] ? (VW'(0) - diag_q) : diag_q;
  assign trial    = {rem_q, dvd_q[ACC_W-1]};
  assign qbit     = trial >= {1'b0, dm_q};

  // Saturate the quotient to the signed value range.
  localparam logic [ACC_W-1:0] Q_LIM = ACC_W'(1) << (VW - 1);
  always_comb begin
    if (neg_q) begin
      xnew = (dvd_q >= Q_LIM) ? {1'b1, {(VW-1){1'b0}}}
                              : VW'(ACC_W'(0) - dvd_q);
    end else begin
      xnew = (dvd_q >= Q_LIM - ACC_W'(1)) ? {1'b0, {(VW-1){1'b1}}}
                                          : dvd_q[VW-1:0];
    end
  end

  // Error sums.
  logic [ES_W-1:0] dsum_q, osum_q, osum_sh, prod_u;
  logic conv;
  assign prod_u  = ES_W'(prod_q[MW-1:0]);
  assign osum_sh = osum_q >> tshift_i;
  assign conv    = (dsum_q == '0) || (dsum_q <= osum_sh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      first1_q <= 1'b0;
      diag1_q  <= 1'b0;
      zpchk1_q <= 1'b0;
      v2_q     <= 1'b0;
      first2_q <= 1'b0;
      diag2_q  <= 1'b0;
      zp_q     <= 1'b0;
      conv_q   <= 1'b0;
      sel_q    <= 1'b0;
      dcnt_q   <= '0;
    end else begin
      v1_q     <= cmd_i.mac_issue;
      first1_q <= cmd_i.mac_first;
      diag1_q  <= row_i == col_i;
      zpchk1_q <= cmd_i.zp_issue;
      v2_q     <= v1_q;
      first2_q <= first1_q;
      diag2_q  <= diag1_q;
      if (cmd_i.zp_clr) begin
        zp_q   <= 1'b0;
        conv_q <= 1'b0;
      end else begin
        if (zpchk1_q && (mat_rd == '0)) begin
          zp_q <= 1'b1;
        end
        if (cmd_i.chk && conv) begin
          conv_q <= 1'b1;
        end
      end
      if (cmd_i.chk) begin
        sel_q <= !sel_q;
      end
      if (cmd_i.div_load) begin
        dcnt_q <= DCNT_W'(ACC_W);
      end else if (cmd_i.div_step && (dcnt_q != '0)) begin
        dcnt_q <= dcnt_q - DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q || cmd_i.sq_d || cmd_i.sq_o) begin
      prod_q <= prod_d;
    end
    if (v1_q && first1_q) begin
      rhs_q <= rhs_rd;
    end
    if (v1_q && diag1_q) begin
      diag_q <= mat_rd;
      oldi_q <= old_rd;
    end
    if (v2_q) begin
      acc_q <= first2_q ? (rhs_ext - term) : (acc_q - term);
    end
    if (cmd_i.div_load) begin
      neg_q <= acc_q[ACC_W-1] ^ diag_q[VW-1];
      dvd_q <= acc_mag;
      dm_q  <= diag_mag;
      rem_q <= '0;
    end else if (cmd_i.div_step && (dcnt_q != '0)) begin
      rem_q <= qbit ? VW'(trial - {1'b0, dm_q}) : trial[VW-1:0];
      dvd_q <= {dvd_q[ACC_W-2:0], qbit};
    end
    if (cmd_i.wr) begin
      diff_q <= $signed({xnew[VW-1], xnew}) - $signed({oldi_q[VW-1], oldi_q});
    end
    if (cmd_i.sums_clr) begin
      dsum_q <= '0;
      osum_q <= '0;
    end else begin
      if (cmd_i.sq_o) begin
        dsum_q <= dsum_q + prod_u;
      end
      if (cmd_i.sq_a) begin
        osum_q <= osum_q + prod_u;
      end
    end
    if (cmd_i.out_ld) begin
      index_o       <= POS_W'(col_i);
      solution_o    <= old_rd;
      last_o        <= cmd_i.last;
      converged_o   <= conv_q;
      zero_pivot_o  <= zp_q;
      sweeps_done_o <= sweeps_i;
    end
  end

  assign status_o.zp       = zp_q;
  assign status_o.conv     = conv;
  assign status_o.div_done = dcnt_q == '0;

endmodule
`default_nettype wire

// ===== sv/jls_ctrl.sv =====
`default_nettype none
module jls_ctrl #(
  parameter int MAX_SIZE = jls_pkg::MAX_SIZE_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [jls_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [jls_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [jls_pkg::OP_W-1:0]      operation_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output jls_pkg::cmd_t                      cmd_o,
  input  wire jls_pkg::status_t              status_i,
  output logic      [$clog2(MAX_SIZE)-1:0]   row_o,
  output logic      [$clog2(MAX_SIZE)-1:0]   col_o,
  output logic      [jls_pkg::SHIFT_W-1:0]   tshift_o,
  output logic      [jls_pkg::SWEEP_W-1:0]   sweeps_o
);
  import jls_pkg::*;

  localparam int IDX_W = $clog2(MAX_SIZE);
  localparam int CNT_W = $clog2(MAX_SIZE + 1);
  localparam int LIM_W = $clog2(255 * MAX_SIZE + 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_ZP_SCAN, ST_ZP_WAIT, ST_DECIDE, ST_ROW_MAC, ST_MAC_DR1, ST_MAC_DR2,
    ST_DIV_LD, ST_DIV_RUN, ST_WR, ST_SQ_D, ST_SQ_O, ST_SQ_A, ST_CHK,
    ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT
  } state_e;

  state_e state_q;
  logic [SIZE_W-1:0]   size_q;
  logic [FACTOR_W-1:0] factor_q;
  logic [SHIFT_W-1:0]  shift_q;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [LIM_W-1:0]    limit_q, sweeps_q, sweeps_inc;
  logic [IDX_W-1:0]    i_q, j_q;
  logic                out_valid_q;
  logic                accept, i_last, j_last;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = state_q != ST_IDLE;
  assign i_last     = CNT_W'(i_q) == CNT_W'(n_q - CNT_W'(1));
  assign j_last     = CNT_W'(j_q) == CNT_W'(n_q - CNT_W'(1));
  assign sweeps_inc = sweeps_q + LIM_W'(1);

  always_comb begin
    if (size_q == '0) begin
      n_d = CNT_W'(1);
    end else if (int'(size_q) > MAX_SIZE) begin
      n_d = CNT_W'(MAX_SIZE);
    end else begin
      n_d = CNT_W'(size_q);
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept && (operation_i != OP_START);
    cmd_o.zp_clr    = accept && (operation_i == OP_START);
    cmd_o.zp_issue  = state_q == ST_ZP_SCAN;
    cmd_o.mac_issue = state_q == ST_ROW_MAC;
    cmd_o.mac_first = (state_q == ST_ROW_MAC) && (j_q == '0);
    cmd_o.div_load  = state_q == ST_DIV_LD;
    cmd_o.div_step  = state_q == ST_DIV_RUN;
    cmd_o.wr        = state_q == ST_WR;
    cmd_o.sq_d      = state_q == ST_SQ_D;
    cmd_o.sq_o      = state_q == ST_SQ_O;
    cmd_o.sq_a      = state_q == ST_SQ_A;
    cmd_o.sums_clr  = (state_q == ST_DECIDE) || (state_q == ST_CHK);
    cmd_o.chk       = state_q == ST_CHK;
    cmd_o.out_ld    = state_q == ST_OUT_LD;
    cmd_o.last      = j_last;
  end

  assign row_o       = i_q;
  assign col_o       = (state_q == ST_ZP_SCAN) ? i_q : j_q;
  assign tshift_o    = shift_q;
  assign sweeps_o    = SWEEP_W'(sweeps_q);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= SIZE_RST;
      factor_q    <= FACTOR_RST;
      shift_q     <= SHIFT_RST;
      n_q         <= '0;
      limit_q     <= '0;
      sweeps_q    <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SIZE:   size_q   <= SIZE_W'(cfg_data_i);
          CFG_FACTOR: factor_q <= cfg_data_i;
          CFG_SHIFT:  shift_q  <= SHIFT_W'(cfg_data_i);
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (operation_i == OP_START)) begin
            n_q      <= n_d;
            limit_q  <= LIM_W'(int'(factor_q) * int'(n_d));
            sweeps_q <= '0;
            i_q      <= '0;
            j_q      <= '0;
            state_q  <= ST_ZP_SCAN;
          end
        end
        ST_ZP_SCAN: begin
          if (i_last) begin
            i_q     <= '0;
            state_q <= ST_ZP_WAIT;
          end else begin
            i_q <= i_q + IDX_W'(1);
          end
        end
        ST_ZP_WAIT: state_q <= ST_DECIDE;
        ST_DECIDE: begin
          i_q <= '0;
          j_q <= '0;
          if (status_i.zp || (limit_q == '0)) begin
            state_q <= ST_OUT_RD;
          end else begin
            state_q <= ST_ROW_MAC;
          end
        end
        ST_ROW_MAC: begin
          if (j_last) begin
            j_q     <= '0;
            state_q <= ST_MAC_DR1;
          end else begin
            j_q <= j_q + IDX_W'(1);
          end
        end
        ST_MAC_DR1: state_q <= ST_MAC_DR2;
        ST_MAC_DR2: state_q <= ST_DIV_LD;
        ST_DIV_LD:  state_q <= ST_DIV_RUN;
        ST_DIV_RUN: begin
          if (status_i.div_done) begin
            state_q <= ST_WR;
          end
        end
        ST_WR:   state_q <= ST_SQ_D;
        ST_SQ_D: state_q <= ST_SQ_O;
        ST_SQ_O: state_q <= ST_SQ_A;
        ST_SQ_A: begin
          if (i_last) begin
            state_q <= ST_CHK;
          end else begin
            i_q     <= i_q + IDX_W'(1);
            state_q <= ST_ROW_MAC;
          end
        end
        ST_CHK: begin
          sweeps_q <= sweeps_inc;
          i_q      <= '0;
          j_q      <= '0;
          if (status_i.conv || (sweeps_inc >= limit_q)) begin
            state_q <= ST_OUT_RD;
          end else begin
            state_q <= ST_ROW_MAC;
          end
        end
        ST_OUT_RD: state_q <= ST_OUT_LD;
        ST_OUT_LD: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_OUT_WAIT;
        end
        ST_OUT_WAIT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (j_last) begin
              state_q <= ST_IDLE;
            end else begin
              j_q     <= j_q + IDX_W'(1);
              state_q <= ST_OUT_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_no_input_while_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> in_stall_o)
    else $error("input taken while a result item is pending");

  a_div_to_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV_RUN && status_i.div_done) |=> (state_q == ST_WR))
    else $error("divider finish not followed by the write step");

  a_sweep_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHK) |=> (sweeps_q == $past(sweeps_q) + LIM_W'(1)))
    else $error("sweep count did not advance");

  a_pivot_abort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && status_i.zp) |=> (state_q == ST_OUT_RD))
    else $error("zero pivot did not abort the run");

endmodule
`default_nettype wire

// ===== sv/jacobi_linear_solver.sv =====
// Load items are taken one per cycle while the block is idle; a start item keeps the input
// stalled until its run ends. Run: a pivot scan, then sweeps of one multiply-accumulate
// per cycle and a bit-serial divider per row; the n result items then come one at a time
// from the solution bank port, each held on the output until it is taken.
// Reset (asynchronous, active low) clears control state and restores the configuration
// defaults; the matrix, right-hand side and solution stores are undefined until written.
`default_nettype none
module jacobi_linear_solver #(
  parameter int MAX_SIZE    = jls_pkg::MAX_SIZE_DEF,
  parameter int VALUE_WIDTH = jls_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [jls_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [jls_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [jls_pkg::OP_W-1:0]      operation_i,
  input  wire logic [jls_pkg::POS_W-1:0]     row_i,
  input  wire logic [jls_pkg::POS_W-1:0]     col_i,
  input  wire logic [VALUE_WIDTH-1:0]        value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [jls_pkg::POS_W-1:0]     index_o,
  output logic      [VALUE_WIDTH-1:0]        solution_o,
  output logic                               last_o,
  output logic                               converged_o,
  output logic                               zero_pivot_o,
  output logic      [jls_pkg::SWEEP_W-1:0]   sweeps_done_o
);
  import jls_pkg::*;

  localparam int IDX_W = $clog2(MAX_SIZE);

  cmd_t                cmd;
  status_t             status;
  logic [IDX_W-1:0]    ctl_row, ctl_col;
  logic [SHIFT_W-1:0]  tshift;
  logic [SWEEP_W-1:0]  sweeps;

  jls_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .operation_i, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .status_i(status), .row_o(ctl_row), .col_o(ctl_col),
    .tshift_o(tshift), .sweeps_o(sweeps)
  );

  jls_datapath #(.MAX_SIZE(MAX_SIZE), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .row_i(ctl_row), .col_i(ctl_col), .tshift_i(tshift), .sweeps_i(sweeps),
    .operation_i, .in_row_i(row_i), .in_col_i(col_i), .value_i,
    .index_o, .solution_o, .last_o, .converged_o, .zero_pivot_o, .sweeps_done_o
  );

endmodule
`default_nettype wire
